// ===== design/ber_pkg.sv =====
// Shared types and constants of the ellipse rasterizer.
`default_nettype none

package ber_pkg;

  localparam int unsigned COORD_BITS_DEF = 11;
  localparam int unsigned AXIS_BITS_DEF  = 10;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUADRANTS      = 4;
  localparam int unsigned COLOR_BITS     = 32;

  // command word kinds
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  // offset move chosen by the error test
  typedef enum logic [1:0] {
    MOVE_DIAG,
    MOVE_HORIZ,
    MOVE_VERT
  } move_e;

  // back end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_MUL_A2B,
    ST_INIT_ERR,
    ST_STEP
  } state_e;

  // error update phases of one step
  typedef enum logic [2:0] {
    SP_MUL_AJ,
    SP_TEST_NEG,
    SP_TEST_POS,
    SP_MUL_BI,
    SP_ADD_B,
    SP_ADD_A,
    SP_DONE
  } step_ph_e;

endpackage

`default_nettype wire

// ===== design/ber_if.sv =====
// Valid/ready channel interfaces for command words and pixel words.
`default_nettype none

interface ber_cmd_if #(
  parameter int unsigned COORD_BITS = ber_pkg::COORD_BITS_DEF,
  parameter int unsigned AXIS_BITS  = ber_pkg::AXIS_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [AXIS_BITS-1:0]  semi_axis_x;
  logic [AXIS_BITS-1:0]  semi_axis_y;
  logic [31:0]           pixel_color;

  modport source (
    output valid, command, center_x, center_y, semi_axis_x, semi_axis_y, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, command, center_x, center_y, semi_axis_x, semi_axis_y, pixel_color,
    output ready
  );
endinterface

interface ber_pix_if #(
  parameter int unsigned COORD_BITS = ber_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic [31:0]                  out_color;
  logic                         last_of_step;
  logic                         shape_done;

  modport source (
    output valid, pixel_x, pixel_y, out_color, last_of_step, shape_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, out_color, last_of_step, shape_done,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/ber_front.sv =====
// Front end: takes command words, classifies them and hands them to the queue.
`default_nettype none

module ber_front #(
  parameter int unsigned COORD_BITS = ber_pkg::COORD_BITS_DEF,
  parameter int unsigned AXIS_BITS  = ber_pkg::AXIS_BITS_DEF,
  parameter int unsigned ENTRY_BITS = 1 + 2 * COORD_BITS + 2 * AXIS_BITS + 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ber_cmd_if.sink                    cmd_i,
  output logic                       push_valid_o,
  input  wire logic                  push_ready_i,
  output logic [ENTRY_BITS-1:0]      push_data_o
);
  import ber_pkg::*;

  logic                  hold_v_q;
  cmd_e                  kind_q;
  logic [COORD_BITS-1:0] cx_q;
  logic [COORD_BITS-1:0] cy_q;
  logic [AXIS_BITS-1:0]  ax_q;
  logic [AXIS_BITS-1:0]  ay_q;
  logic [COLOR_BITS-1:0] color_q;
  logic                  take;
  cmd_e                  kind;

  // one holding stage, refilled in the cycle it drains
  assign cmd_i.ready = !hold_v_q || push_ready_i;
  assign take        = cmd_i.valid && cmd_i.ready;
  assign kind        = cmd_e'(cmd_i.command);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
    end else if (take) begin
      hold_v_q <= 1'b1;
    end else if (push_ready_i) begin
      hold_v_q <= 1'b0;
    end
  end

  // shape fields only matter to a start word
  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= kind;
      if (kind == CMD_START) begin
        cx_q    <= cmd_i.center_x;
        cy_q    <= cmd_i.center_y;
        ax_q    <= cmd_i.semi_axis_x;
        ay_q    <= cmd_i.semi_axis_y;
        color_q <= cmd_i.pixel_color;
      end
    end
  end

  assign push_valid_o = hold_v_q;
  assign push_data_o  = {kind_q, cx_q, cy_q, ax_q, ay_q, color_q};

endmodule

`default_nettype wire

// ===== design/ber_queue.sv =====
// Small first-in first-out queue between front end and back end.
`default_nettype none

module ber_queue #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = ber_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW:0]      wr_ptr_q;
  logic [AW:0]      rd_ptr_q;
  logic [AW:0]      count;
  logic             push;
  logic             pop;

  // occupancy from the wrap-extended pointers
  assign count        = wr_ptr_q - rd_ptr_q;
  assign push_ready_o = (count != (AW + 1)'(DEPTH));
  assign pop_valid_o  = (count != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q[AW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q[AW-1:0]] <= push_data_i;
  end

  // occupancy bookkeeping
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= (AW + 1)'(DEPTH))
    else $error("queue occupancy beyond depth");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue push lost");

endmodule

`default_nettype wire

// ===== design/ber_back.sv =====
// Back end: squares the axes, walks the error term and emits mirrored pixels.
`default_nettype none

module ber_back #(
  parameter int unsigned COORD_BITS = ber_pkg::COORD_BITS_DEF,
  parameter int unsigned AXIS_BITS  = ber_pkg::AXIS_BITS_DEF,
  parameter int unsigned ENTRY_BITS = 1 + 2 * COORD_BITS + 2 * AXIS_BITS + 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  pop_valid_i,
  output logic                       pop_ready_o,
  input  wire logic [ENTRY_BITS-1:0] pop_data_i,
  ber_pix_if.source                  pix_o
);
  import ber_pkg::*;

  localparam int unsigned SQ   = 2 * AXIS_BITS;
  localparam int unsigned ERR  = 3 * AXIS_BITS + 6;
  localparam int unsigned MB   = (AXIS_BITS > COORD_BITS) ? AXIS_BITS : COORD_BITS;
  localparam int unsigned PW   = SQ + MB;
  localparam int unsigned CW   = ((ERR > PW + 1) ? ERR : PW + 1) + 3;
  localparam int unsigned PIX  = COORD_BITS + 2;
  localparam int unsigned AC   = AXIS_BITS + COORD_BITS;
  localparam logic [2:0] EMIT_DONE = 3'(QUADRANTS);

  // queue word fields
  cmd_e                  pop_cmd;
  logic [COORD_BITS-1:0] pop_cx;
  logic [COORD_BITS-1:0] pop_cy;
  logic [AXIS_BITS-1:0]  pop_ax;
  logic [AXIS_BITS-1:0]  pop_ay;
  logic [COLOR_BITS-1:0] pop_color;

  assign pop_cmd   = cmd_e'(pop_data_i[ENTRY_BITS-1]);
  assign pop_cx    = pop_data_i[ENTRY_BITS-2 -: COORD_BITS];
  assign pop_cy    = pop_data_i[ENTRY_BITS-2-COORD_BITS -: COORD_BITS];
  assign pop_ax    = pop_data_i[2*AXIS_BITS+COLOR_BITS-1 -: AXIS_BITS];
  assign pop_ay    = pop_data_i[AXIS_BITS+COLOR_BITS-1 -: AXIS_BITS];
  assign pop_color = pop_data_i[COLOR_BITS-1:0];

  state_e                state_q, state_d;
  step_ph_e              ph_q, ph_d;
  logic [2:0]            emit_q;
  logic                  active_q;
  logic [COORD_BITS-1:0] i_q, j_q, in_q, jn_q;
  logic [COORD_BITS-1:0] in_d, jn_d;
  logic signed [ERR-1:0] d_q;
  logic [SQ-1:0]         a2_q, b2_q;
  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic [COLOR_BITS-1:0] color_q;
  logic [AXIS_BITS-1:0]  ax_q, ay_q;
  logic [AC-1:0]         ay_ext;
  move_e                 move_q, move_d;
  logic                  neg_diag_q;
  logic [PW-1:0]         prod_q;
  logic [SQ-1:0]         mul_a;
  logic [MB-1:0]         mul_b;
  logic                  emit_load;
  logic                  final_step;
  logic                  step_end;

  logic                  out_valid_q;
  logic [PIX-1:0]        px_q, py_q;
  logic [COLOR_BITS-1:0] ocolor_q;
  logic                  last_q, done_q;

  // error tests at a width that cannot overflow
  logic signed [CW-1:0]  d_w, prod_w, a2_w, b2_w, neg_sum, pos_sum;
  logic                  neg_diag, pos_diag;

  assign d_w     = {{(CW - ERR){d_q[ERR-1]}}, d_q};
  assign prod_w  = {{(CW - PW){1'b0}}, prod_q};
  assign a2_w    = {{(CW - SQ){1'b0}}, a2_q};
  assign b2_w    = {{(CW - SQ){1'b0}}, b2_q};
  assign neg_sum = ((d_w + prod_w) <<< 1) - a2_w;
  assign pos_sum = ((d_w - prod_w) <<< 1) - b2_w;
  assign neg_diag = !neg_sum[CW-1] && (neg_sum != '0);
  assign pos_diag = pos_sum[CW-1];

  assign final_step = (j_q == '0);
  assign step_end   = (state_q == ST_STEP) && (emit_q == EMIT_DONE) &&
                      (final_step || (ph_q == SP_DONE));
  assign ay_ext     = AC'(ay_q);

  // move choice from the error sign and the two delta tests
  always_comb begin
    if (d_q == '0) begin
      move_d = MOVE_DIAG;
    end else if (d_q[ERR-1]) begin
      move_d = neg_diag_q ? MOVE_DIAG : MOVE_HORIZ;
    end else begin
      move_d = pos_diag ? MOVE_DIAG : MOVE_VERT;
    end
    in_d = (move_d != MOVE_VERT)  ? i_q + 1'b1 : i_q;
    jn_d = (move_d != MOVE_HORIZ) ? j_q - 1'b1 : j_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          if (pop_cmd == CMD_START) begin
            state_d = ST_SQ_A;
          end else if (active_q) begin
            state_d = ST_STEP;
          end
        end
      end
      ST_SQ_A:     state_d = ST_SQ_B;
      ST_SQ_B:     state_d = ST_MUL_A2B;
      ST_MUL_A2B:  state_d = ST_INIT_ERR;
      ST_INIT_ERR: state_d = ST_IDLE;
      ST_STEP: begin
        if (step_end) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // step phase sequence
  always_comb begin
    ph_d = ph_q;
    if (state_q == ST_IDLE) begin
      ph_d = SP_MUL_AJ;
    end else if (state_q == ST_STEP && !final_step) begin
      unique case (ph_q)
        SP_MUL_AJ:   ph_d = SP_TEST_NEG;
        SP_TEST_NEG: ph_d = SP_TEST_POS;
        SP_TEST_POS: ph_d = SP_MUL_BI;
        SP_MUL_BI:   ph_d = SP_ADD_B;
        SP_ADD_B:    ph_d = SP_ADD_A;
        SP_ADD_A:    ph_d = SP_DONE;
        SP_DONE:     ph_d = SP_DONE;
        default:     ph_d = SP_DONE;
      endcase
    end
  end

  // queue pop, multiplier operands, pixel load
  always_comb begin
    pop_ready_o = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    emit_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:     pop_ready_o = 1'b1;
      ST_SQ_A: begin
        mul_a = SQ'(ax_q);
        mul_b = MB'(ax_q);
      end
      ST_SQ_B: begin
        mul_a = SQ'(ay_q);
        mul_b = MB'(ay_q);
      end
      ST_MUL_A2B: begin
        mul_a = a2_q;
        mul_b = MB'(ay_q);
      end
      ST_INIT_ERR: ;
      ST_STEP: begin
        emit_load = (emit_q != EMIT_DONE) && (!out_valid_q || pix_o.ready);
        case (ph_q)
          SP_MUL_AJ: begin
            mul_a = a2_q;
            mul_b = MB'(j_q);
          end
          SP_TEST_NEG: begin
            mul_a = b2_q;
            mul_b = MB'(i_q);
          end
          SP_MUL_BI: begin
            mul_a = b2_q;
            mul_b = MB'(in_q);
          end
          SP_ADD_B: begin
            mul_a = a2_q;
            mul_b = MB'(jn_q);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= SP_MUL_AJ;
      emit_q      <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      if (state_q == ST_IDLE) begin
        emit_q <= '0;
      end else if (emit_load) begin
        emit_q <= emit_q + 1'b1;
      end
      if (state_q == ST_INIT_ERR) begin
        active_q <= 1'b1;
      end else if (step_end && final_step) begin
        active_q <= 1'b0;
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // shared multiplier, one product per cycle
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // shape datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i && pop_cmd == CMD_START) begin
          cx_q    <= pop_cx;
          cy_q    <= pop_cy;
          color_q <= pop_color;
          ax_q    <= pop_ax;
          ay_q    <= pop_ay;
        end
      end
      ST_SQ_B:    a2_q <= prod_q[SQ-1:0];
      ST_MUL_A2B: b2_q <= prod_q[SQ-1:0];
      ST_INIT_ERR: begin
        d_q <= ERR'(a2_q) + ERR'(b2_q) - ERR'({prod_q, 1'b0});
        i_q <= '0;
        j_q <= ay_ext[COORD_BITS-1:0];
      end
      ST_STEP: begin
        if (!final_step) begin
          case (ph_q)
            SP_TEST_NEG: neg_diag_q <= neg_diag;
            SP_TEST_POS: begin
              move_q <= move_d;
              in_q   <= in_d;
              jn_q   <= jn_d;
            end
            SP_ADD_B: begin
              if (move_q != MOVE_VERT) begin
                d_q <= d_q + ERR'({prod_q, 1'b0}) + ERR'(b2_q);
              end
            end
            SP_ADD_A: begin
              if (move_q != MOVE_HORIZ) begin
                d_q <= d_q + ERR'(a2_q) - ERR'({prod_q, 1'b0});
              end
            end
            default: ;
          endcase
        end
        if (step_end && !final_step) begin
          i_q <= in_q;
          j_q <= jn_q;
        end
      end
      default: ;
    endcase
  end

  // output register: quadrant order +i+j, +i-j, -i+j, -i-j
  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      px_q     <= emit_q[1] ? PIX'(cx_q) - PIX'(i_q) : PIX'(cx_q) + PIX'(i_q);
      py_q     <= emit_q[0] ? PIX'(cy_q) - PIX'(j_q) : PIX'(cy_q) + PIX'(j_q);
      ocolor_q <= color_q;
      last_q   <= (emit_q[1:0] == 2'(QUADRANTS - 1));
      done_q   <= (emit_q[1:0] == 2'(QUADRANTS - 1)) && final_step;
    end
  end

  assign pix_o.valid        = out_valid_q;
  assign pix_o.pixel_x      = px_q;
  assign pix_o.pixel_y      = py_q;
  assign pix_o.out_color    = ocolor_q;
  assign pix_o.last_of_step = last_q;
  assign pix_o.shape_done   = done_q;

  // sequencing checks
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.shape_done) |-> pix_o.last_of_step)
    else $error("shape done without last pixel of step");
  a_final_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_end && final_step) |=> !active_q)
    else $error("drawing still active after final step");
  a_step_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> active_q)
    else $error("step executed while idle");
  a_end_all_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_end |-> (emit_q == EMIT_DONE))
    else $error("step ended before its pixels were loaded");

endmodule

`default_nettype wire

// ===== design/bresenham_ellipse_raster.sv =====
// Order: a step word passes the front holding register, the queue, the back end sequencer
// and the output register, then gives one pixel a cycle while the receiver is ready. A start
// word gives no pixels and holds the back end in ST_SQ_A, ST_SQ_B, ST_MUL_A2B and ST_INIT_ERR.
// A step but the final one runs the 6 error update phases on the shared multiplier beside the 4 pixel loads.
// Reset: asynchronous, active low; sequencer idle, queue empty, no shape active.
`default_nettype none

module bresenham_ellipse_raster #(
  parameter int unsigned COORD_BITS = ber_pkg::COORD_BITS_DEF,
  parameter int unsigned AXIS_BITS  = ber_pkg::AXIS_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ber_cmd_if.sink   cmd_i,
  ber_pix_if.source pix_o
);
  import ber_pkg::*;

  localparam int unsigned ENTRY_BITS = 1 + 2 * COORD_BITS + 2 * AXIS_BITS + COLOR_BITS;

  logic                  push_valid;
  logic                  push_ready;
  logic [ENTRY_BITS-1:0] push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [ENTRY_BITS-1:0] pop_data;

  ber_front #(
    .COORD_BITS (COORD_BITS),
    .AXIS_BITS  (AXIS_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ber_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ber_back #(
    .COORD_BITS (COORD_BITS),
    .AXIS_BITS  (AXIS_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .pix_o       (pix_o)
  );

endmodule

`default_nettype wire

// ===== bench/ellipse_checker.sv =====
// Pixel checker for the ellipse rasterizer: tracks the shape state and compares pixel words.
module ellipse_checker #(
  parameter int unsigned COORD_BITS = ber_pkg::COORD_BITS_DEF,
  parameter int unsigned AXIS_BITS  = ber_pkg::AXIS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ber_cmd_if          cmd_w,
  ber_pix_if          pix_w,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import ber_pkg::*;

  localparam int unsigned PIX_W = COORD_BITS + 2;
  localparam int unsigned ERR_W = 3 * AXIS_BITS + 6;
  localparam int unsigned SQ_W  = 2 * AXIS_BITS;

  typedef struct packed {
    logic [PIX_W-1:0]      x;
    logic [PIX_W-1:0]      y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
    logic                  done;
  } pixel_t;

  pixel_t expected_pixels[$];

  // shape state as the rasterizer should hold it
  logic [COORD_BITS-1:0]   ofs_x;
  logic [COORD_BITS-1:0]   ofs_y;
  logic [COORD_BITS-1:0]   ctr_x;
  logic [COORD_BITS-1:0]   ctr_y;
  logic signed [ERR_W-1:0] err_acc;
  logic [SQ_W-1:0]         ax_sq;
  logic [SQ_W-1:0]         ay_sq;
  logic [COLOR_BITS-1:0]   ink;
  logic                    tracing;
  int unsigned             misses;

  task automatic report_miss(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    $display("ERROR %s: got %0h expected %0h at %0t", what, got, want, $time);
    misses++;
  endtask

  // one mirrored pixel; coordinates wrap at the pixel width
  function automatic pixel_t mirror_pixel(input longint px, input longint py,
                                          input logic last, input logic done);
    pixel_t p;
    p.x     = px[PIX_W-1:0];
    p.y     = py[PIX_W-1:0];
    p.color = ink;
    p.last  = last;
    p.done  = done;
    return p;
  endfunction

  // apply one accepted command word and queue the pixels it should emit
  task automatic advance_ellipse();
    longint ax, ay, a2, b2, d, i, j, cx, cy;
    move_e  mv;
    if (cmd_e'(cmd_w.command) == CMD_START) begin
      ax      = cmd_w.semi_axis_x;
      ay      = cmd_w.semi_axis_y;
      a2      = ax * ax;
      b2      = ay * ay;
      ctr_x   = cmd_w.center_x;
      ctr_y   = cmd_w.center_y;
      ink     = cmd_w.pixel_color;
      ax_sq   = a2[SQ_W-1:0];
      ay_sq   = b2[SQ_W-1:0];
      ofs_x   = '0;
      ofs_y   = ay[COORD_BITS-1:0];
      d       = a2 + b2 - 2 * a2 * ay;
      err_acc = d[ERR_W-1:0];
      tracing = 1'b1;
    end else if (tracing) begin
      cx = ctr_x;
      cy = ctr_y;
      i  = ofs_x;
      j  = ofs_y;
      a2 = ax_sq;
      b2 = ay_sq;
      d  = err_acc;
      expected_pixels.push_back(mirror_pixel(cx + i, cy + j, 1'b0, 1'b0));
      expected_pixels.push_back(mirror_pixel(cx + i, cy - j, 1'b0, 1'b0));
      expected_pixels.push_back(mirror_pixel(cx - i, cy + j, 1'b0, 1'b0));
      expected_pixels.push_back(mirror_pixel(cx - i, cy - j, 1'b1, j == 0));
      if (j == 0) begin
        tracing = 1'b0;
      end else begin
        // pick the move from the error sign and the two delta tests
        if (d == 0) begin
          mv = MOVE_DIAG;
        end else if (d < 0) begin
          mv = (2 * (d + a2 * j) - a2 > 0) ? MOVE_DIAG : MOVE_HORIZ;
        end else begin
          mv = (2 * (d - b2 * i) - b2 < 0) ? MOVE_DIAG : MOVE_VERT;
        end
        if (mv != MOVE_VERT) begin
          i = (i + 1) & ((longint'(1) << COORD_BITS) - 1);
          d = d + b2 * (2 * i + 1);
        end
        if (mv != MOVE_HORIZ) begin
          j = j - 1;
          d = d + a2 * (1 - 2 * j);
        end
        ofs_x   = i[COORD_BITS-1:0];
        ofs_y   = j[COORD_BITS-1:0];
        err_acc = d[ERR_W-1:0];
      end
    end
  endtask

  // compare one accepted pixel word with the oldest expectation
  task automatic check_pixel();
    pixel_t got, want;
    got.x     = pix_w.pixel_x[PIX_W-1:0];
    got.y     = pix_w.pixel_y[PIX_W-1:0];
    got.color = pix_w.out_color;
    got.last  = pix_w.last_of_step;
    got.done  = pix_w.shape_done;
    if (expected_pixels.size() == 0) begin
      report_miss("pixel word with none expected, x", got.x, '0);
    end else begin
      want = expected_pixels.pop_front();
      if (got.x != want.x) report_miss("pixel_x", got.x, want.x);
      if (got.y != want.y) report_miss("pixel_y", got.y, want.y);
      if (got.color != want.color) report_miss("out_color", got.color, want.color);
      if (got.last != want.last) report_miss("last_of_step", got.last, want.last);
      if (got.done != want.done) report_miss("shape_done", got.done, want.done);
    end
  endtask

  // pixels are checked before the command of the same edge: a step never
  // yields a pixel in the cycle it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_pixels.delete();
      ofs_x        = '0;
      ofs_y        = '0;
      ctr_x        = '0;
      ctr_y        = '0;
      err_acc      = '0;
      ax_sq        = '0;
      ay_sq        = '0;
      ink          = '0;
      tracing      = 1'b0;
      misses       = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (pix_w.valid && pix_w.ready) check_pixel();
      if (cmd_w.valid && cmd_w.ready) advance_ellipse();
      fail_count_o <= misses;
      pending_o    <= expected_pixels.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the ellipse rasterizer bench: clock, reset, command stimulus, pixel stalls, verdict.
module tb_top;
  import ber_pkg::*;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_THREE_IN_FOUR,
    RX_SPARSE
  } stall_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending_pixels;
  int unsigned words_sent;
  int unsigned burst_left;
  logic        sending;
  stall_e      stall_mode;
  logic [4:0]  stall_tick;

  ber_cmd_if cmd_if ();
  ber_pix_if pix_if ();

  bresenham_ellipse_raster u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .pix_o  (pix_if)
  );

  ellipse_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_w        (cmd_if),
    .pix_w        (pix_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_pixels)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop if the pixel stream stalls for good
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: stall pattern picked at random each time the 5-bit stall_tick wraps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_if.ready <= 1'b0;
      stall_tick   <= '0;
      stall_mode   <= RX_FREE;
    end else begin
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick == '0) stall_mode <= stall_e'($urandom_range(0, 3));
      case (stall_mode)
        RX_FREE:          pix_if.ready <= 1'b1;
        RX_COIN:          pix_if.ready <= 1'($urandom_range(0, 1));
        RX_THREE_IN_FOUR: pix_if.ready <= (stall_tick[1:0] != 2'd0);
        default:          pix_if.ready <= (stall_tick[2:0] == 3'd0);
      endcase
    end
  end

  // drive one command word and hold it until taken; bursts end in random gaps
  task automatic put_word(input cmd_e kind, input logic [10:0] cx, input logic [10:0] cy,
                          input logic [9:0] ax, input logic [9:0] ay,
                          input logic [31:0] color);
    int unsigned gap;
    cmd_if.valid       <= 1'b1;
    cmd_if.command     <= kind;
    cmd_if.center_x    <= cx;
    cmd_if.center_y    <= cy;
    cmd_if.semi_axis_x <= ax;
    cmd_if.semi_axis_y <= ay;
    cmd_if.pixel_color <= color;
    sending = 1'b1;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? 32 : $urandom_range(1, 10);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        sending = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // step words carry random junk in the unused fields
  task automatic put_step();
    put_word(CMD_STEP, 11'($urandom), 11'($urandom), 10'($urandom), 10'($urandom),
             $urandom);
  endtask

  // hold the command line idle until every predicted pixel has come out
  task automatic wait_drained();
    if (sending) begin
      cmd_if.valid <= 1'b0;
      sending = 1'b0;
    end
    @(posedge clk_i);
    while (pending_pixels != 0) @(posedge clk_i);
  endtask

  // one random shape: mostly small and complete, some cut short, a few huge
  task automatic random_shape();
    logic [9:0]  ax, ay;
    int unsigned n_steps, pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      ax      = 10'($urandom);
      ay      = 10'($urandom);
      n_steps = $urandom_range(0, 6);
    end else if (pick < 3) begin
      ax      = 10'($urandom_range(0, 24));
      ay      = 10'($urandom_range(0, 24));
      n_steps = ax + ay + 1;
    end else begin
      ax      = 10'($urandom_range(0, 9));
      ay      = 10'($urandom_range(0, 9));
      n_steps = ax + ay + 1;
    end
    if (pick != 0 && $urandom_range(0, 6) == 0) n_steps = $urandom_range(0, n_steps);
    put_word(CMD_START, 11'($urandom), 11'($urandom), ax, ay, $urandom);
    repeat (n_steps) begin
      put_step();
    end
    // a few extra steps: finish a long shape or land on an idle block
    repeat ($urandom_range(0, 2)) put_step();
    if ($urandom_range(0, 9) == 0) wait_drained();
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cmd_if.valid       <= 1'b0;
    cmd_if.command     <= CMD_START;
    cmd_if.center_x    <= '0;
    cmd_if.center_y    <= '0;
    cmd_if.semi_axis_x <= '0;
    cmd_if.semi_axis_y <= '0;
    cmd_if.pixel_color <= '0;
    sending    = 1'b0;
    burst_left = 1;
    words_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: step on an idle block
    put_step();
    // zero axes: first step is the last, the next one is ignored
    put_word(CMD_START, 11'd0, 11'd0, 10'd0, 10'd0, 32'h0000_0000);
    put_step();
    put_step();
    // largest axes at the top corner, abandoned by the next start
    put_word(CMD_START, 11'h7FF, 11'h7FF, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
    repeat (3) put_step();
    // largest axes at the origin: most negative coordinates
    put_word(CMD_START, 11'd0, 11'd0, 10'h3FF, 10'h3FF, 32'h5A5A_A5A5);
    put_step();
    // zero horizontal axis: vertical moves only, then one idle step
    put_word(CMD_START, 11'd0, 11'd0, 10'd0, 10'd3, 32'h0000_FFFF);
    repeat (5) put_step();
    // zero vertical axis: first step ends the shape
    put_word(CMD_START, 11'd100, 11'd200, 10'd5, 10'd0, 32'hA5A5_5A5A);
    put_step();
    // small full ellipse
    put_word(CMD_START, 11'd1000, 11'd7, 10'd3, 10'd2, 32'hFFFF_0000);
    repeat (6) put_step();
    wait_drained();

    // random shapes, with a full drain when the word count lands between 100 and 114
    while (words_sent < 210) begin
      random_shape();
      if (words_sent >= 100 && words_sent < 115) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ber_pkg.sv
design/ber_if.sv
design/ber_front.sv
design/ber_queue.sv
design/ber_back.sv
design/bresenham_ellipse_raster.sv
bench/ellipse_checker.sv
bench/tb_top.sv
